// ===== rtl/yrgb_pkg.sv =====
// Shared types, constants and the fixed-point clamp for the YUYV to RGB converter.
`timescale 1ns / 1ps
package yrgb_pkg;

  localparam int Q_SHIFT = 12;
  localparam int SUM_W   = 23;  // exact signed sum for every channel

  localparam logic signed [SUM_W-1:0] K_RV = 23'sd5743;
  localparam logic signed [SUM_W-1:0] K_GU = 23'sd1409;
  localparam logic signed [SUM_W-1:0] K_GV = 23'sd2925;
  localparam logic signed [SUM_W-1:0] K_BU = 23'sd7258;

  typedef logic signed [SUM_W-1:0] sum_t;

  // Chroma contributions shared by both pixels of a macropixel.
  typedef struct packed {
    sum_t r_v;
    sum_t g_u;
    sum_t g_v;
    sum_t b_u;
  } chroma_terms_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  // Floor the Q12 sum and clamp it to 0..255.
  function automatic logic [7:0] fix_to_byte(input sum_t s);
    logic [7:0] res;
    if (s[SUM_W-1]) begin
      res = 8'd0;
    end else if (|s[SUM_W-2:Q_SHIFT+8]) begin
      res = 8'd255;
    end else begin
      res = s[Q_SHIFT+7:Q_SHIFT];
    end
    return res;
  endfunction

endpackage

// ===== rtl/yrgb_chroma.sv =====
// Shared chroma stage: offset removal and registered coefficient products.
`timescale 1ns / 1ps
module yrgb_chroma (
  input  logic                  clk,
  input  logic                  load,
  input  logic [7:0]            chroma_blue,
  input  logic [7:0]            chroma_red,
  output yrgb_pkg::chroma_terms_t terms
);
  import yrgb_pkg::*;

  logic signed [7:0] du;
  logic signed [7:0] dv;
  sum_t              du_ext;
  sum_t              dv_ext;
  chroma_terms_t     terms_r;
  chroma_terms_t     terms_nxt;

  // Byte minus 128 is the byte with its top bit flipped, read as signed.
  assign du     = {~chroma_blue[7], chroma_blue[6:0]};
  assign dv     = {~chroma_red[7], chroma_red[6:0]};
  assign du_ext = {{(SUM_W-8){du[7]}}, du};
  assign dv_ext = {{(SUM_W-8){dv[7]}}, dv};

  always_comb begin
    terms_nxt.r_v = K_RV * dv_ext;
    terms_nxt.g_u = K_GU * du_ext;
    terms_nxt.g_v = K_GV * dv_ext;
    terms_nxt.b_u = K_BU * du_ext;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      terms_r <= terms_nxt;
    end
  end

  assign terms = terms_r;

endmodule

// ===== rtl/yrgb_lane.sv =====
// One pixel lane: adds luma to the shared chroma terms, floors and clamps.
`timescale 1ns / 1ps
module yrgb_lane (
  input  logic [7:0]              luma,
  input  yrgb_pkg::chroma_terms_t terms,
  output yrgb_pkg::rgb_t          pixel
);
  import yrgb_pkg::*;

  sum_t base;
  sum_t sum_r;
  sum_t sum_g;
  sum_t sum_b;

  assign base  = {{(SUM_W-8-Q_SHIFT){1'b0}}, luma, {Q_SHIFT{1'b0}}};
  assign sum_r = base + terms.r_v;
  assign sum_g = base - terms.g_u - terms.g_v;
  assign sum_b = base + terms.b_u;

  assign pixel.red   = fix_to_byte(sum_r);
  assign pixel.green = fix_to_byte(sum_g);
  assign pixel.blue  = fix_to_byte(sum_b);

endmodule

// ===== rtl/yuyv_to_rgb_converter.sv =====
// Top level: YUYV macropixel in, two full-range BT.601 RGB pixels out.
//
//   channel | ports                                   | width
//   --------+-----------------------------------------+-------------
//   in      | in_valid, in_ready, in_luma_even,        | 4 x 8 bits
//           | in_chroma_blue, in_luma_odd, in_chroma_red|
//   out     | out_valid, out_ready, out_{red,green,    | 6 x 8 bits
//           | blue}_{even,odd}                         |
//
// One beat per cycle sustained while out_ready is high; each beat passes through
// a chroma product register, then two pixel lanes merged into the output register.
// Reset clears only the two stage valid bits; payload registers are not reset.
// A stalled output holds both stages; in_ready follows out_ready when both are full.
`timescale 1ns / 1ps
module yuyv_to_rgb_converter (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_luma_even,
  input  logic [7:0] in_chroma_blue,
  input  logic [7:0] in_luma_odd,
  input  logic [7:0] in_chroma_red,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_red_even,
  output logic [7:0] out_green_even,
  output logic [7:0] out_blue_even,
  output logic [7:0] out_red_odd,
  output logic [7:0] out_green_odd,
  output logic [7:0] out_blue_odd
);
  import yrgb_pkg::*;

  logic          s1_v_r;
  logic          s1_v_nxt;
  logic          out_v_r;
  logic          out_v_nxt;
  logic          s1_adv;
  logic          s2_adv;
  logic          s1_load;
  logic          s2_load;
  logic [7:0]    y_even_r;
  logic [7:0]    y_odd_r;
  chroma_terms_t terms;
  rgb_t          lane_even;
  rgb_t          lane_odd;
  rgb_t          pix_even_r;
  rgb_t          pix_odd_r;

  assign s2_adv   = !out_v_r || out_ready;
  assign s1_adv   = !s1_v_r || s2_adv;
  assign in_ready = s1_adv;
  assign s1_load  = s1_adv && in_valid;
  assign s2_load  = s2_adv && s1_v_r;

  always_comb begin
    s1_v_nxt  = s1_adv ? in_valid : s1_v_r;
    out_v_nxt = s2_adv ? s1_v_r : out_v_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      y_even_r <= in_luma_even;
      y_odd_r  <= in_luma_odd;
    end
  end

  yrgb_chroma u_chroma (
    .clk         (clk),
    .load        (s1_load),
    .chroma_blue (in_chroma_blue),
    .chroma_red  (in_chroma_red),
    .terms       (terms)
  );

  yrgb_lane u_lane_even (
    .luma  (y_even_r),
    .terms (terms),
    .pixel (lane_even)
  );

  yrgb_lane u_lane_odd (
    .luma  (y_odd_r),
    .terms (terms),
    .pixel (lane_odd)
  );

  // Merge both lanes into the output register.
  always_ff @(posedge clk) begin
    if (s2_load) begin
      pix_even_r <= lane_even;
      pix_odd_r  <= lane_odd;
    end
  end

  assign out_valid      = out_v_r;
  assign out_red_even   = pix_even_r.red;
  assign out_green_even = pix_even_r.green;
  assign out_blue_even  = pix_even_r.blue;
  assign out_red_odd    = pix_odd_r.red;
  assign out_green_odd  = pix_odd_r.green;
  assign out_blue_odd   = pix_odd_r.blue;

  a_in_fills_s1 : assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> s1_v_r)
    else $error("accepted beat did not reach the chroma stage");

  a_s1_moves_out : assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && s2_adv) |=> out_valid)
    else $error("chroma stage beat lost before output");

  a_reset_clears : assert property (@(posedge clk)
    !rst_n |=> (!out_valid && !s1_v_r))
    else $error("stage valid bits not cleared by reset");

  a_empty_out_ready : assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled while output stage empty");

endmodule
